// ===== hw/rtl/rsp_pkg.sv =====
// Shared types, constants and codes of the road segment perspective projector.
package rsp_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_ROAD_WIDTH    = 3'd2,
		REG_CAMERA_HEIGHT = 3'd3,
		REG_CAMERA_DEPTH  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [11:0] screen_width;
		logic [11:0] screen_height;
		logic [15:0] road_width;
		logic [15:0] camera_height;
		logic [15:0] camera_depth;   // unsigned Q0.16
	} cfg_t;

	localparam logic [11:0] SCREEN_WIDTH_RST  = 12'd1024;
	localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd768;
	localparam logic [15:0] ROAD_WIDTH_RST    = 16'd2000;
	localparam logic [15:0] CAMERA_HEIGHT_RST = 16'd1500;
	localparam logic [15:0] CAMERA_DEPTH_RST  = 16'd55050;

	// Request payloads
	typedef struct packed {
		logic        [19:0] segment_depth;
		logic signed [7:0]  segment_curve;
		logic        [15:0] segment_number;
		logic signed [23:0] player_offset;
		logic        [19:0] camera_z;
		logic               frame_start;
	} seg_req_t;

	typedef struct packed {
		logic signed [15:0] centre_x;
		logic signed [15:0] row_y;
		logic signed [15:0] half_width;
		logic signed [15:0] rumble_width;
		logic signed [15:0] prev_centre_x;
		logic signed [15:0] prev_row_y;
		logic signed [15:0] prev_half_width;
		logic               shade;
		logic               visible;
	} proj_req_t;

	// Divider geometry: quotients saturate at 16 bits, so 16 restoring steps
	localparam int QUO_W     = 16;
	localparam int DIV_STEPS = QUO_W;
	localparam int NUM_W     = 58;                     // numerator magnitude
	localparam int DEN_W     = 40;                     // divisor
	localparam int SH_W      = DEN_W + DIV_STEPS - 1;  // divisor at top step
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	localparam logic signed [QUO_W-1:0] SAT_MAX   = 16'sh7FFF;
	localparam logic signed [QUO_W-1:0] SAT_MIN   = 16'sh8000;
	localparam logic        [QUO_W-1:0] NEG_LIMIT = 16'd32768;

	// n/3 for 16-bit n: (n * 43691) >> 17
	localparam logic [15:0] DIV3_RECIP = 16'd43691;
	localparam int          DIV3_SHIFT = 17;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_NUM,
		ST_START_A,
		ST_WAIT_A,
		ST_WAIT_B
	} state_t;

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic num;
		logic start_a;
		logic start_b;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
	} dp_sts_t;

endpackage

// ===== hw/rtl/road_segment_perspective_projector.sv =====
// Top level of the road segment perspective projector.
// Projects one road segment per request onto the screen: depth = segment z minus camera z,
// then centre column, row, road half-width and rumble half-width (x1.2), each truncated
// toward zero and saturated to 16 bits signed, alongside the previous segment's column,
// row and half-width, a two-shade band bit and a visible flag. A request with frame_start
// clears the curve accumulators and the previous segment before it is handled. A request
// passes through capture, two product steps and a numerator step, then two rounds of 16
// restoring divide steps with two dividers side by side (column and half-width, then row
// and rumble width). A finished result waits in an output register, so the next request
// is taken while it waits. Configuration is written through cfg_we / cfg_index / cfg_data
// only while the block is idle: this binds the user, and the block itself does not
// enforce it. Unmapped indexes are ignored.
module road_segment_perspective_projector (
	input  logic                            clk,
	input  logic                            arst_n,
	// segment requests
	input  logic                            seg_valid,
	output logic                            seg_ready,
	input  rsp_pkg::seg_req_t               seg_data,
	// projected results
	output logic                            proj_valid,
	input  logic                            proj_ready,
	output rsp_pkg::proj_req_t              proj_data,
	// configuration writes
	input  logic                            cfg_we,
	input  logic [rsp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rsp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rsp_pkg::*;

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;

	// screen size, road width, camera height and depth factor
	rsp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer: owns the handshakes and the result valid flag
	rsp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.seg_valid  (seg_valid),
		.seg_ready  (seg_ready),
		.proj_valid (proj_valid),
		.proj_ready (proj_ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	// arithmetic, running curve and previous-segment state, result register
	rsp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_data  (seg_data),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.proj_data (proj_data)
	);

endmodule

// ===== hw/rtl/rsp_div.sv =====
// Saturating restoring divider: 16 quotient bits, one per cycle.
module rsp_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [rsp_pkg::NUM_W-1:0]       num_mag,
	input  logic                            num_neg,
	input  logic [rsp_pkg::DEN_W-1:0]       den,
	output logic                            busy,
	output logic signed [rsp_pkg::QUO_W-1:0] quo
);
	import rsp_pkg::*;

	logic [CNT_W-1:0]     cnt_q;
	logic [NUM_W-1:0]     rem_q;
	logic [SH_W-1:0]      dsh_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic                 ovf_q;
	logic                 neg_q;

	logic [NUM_W-1:0] den_top;
	logic [NUM_W-1:0] dsh_ext;
	logic             rem_ge;

	// quotient of 2^16 or more saturates regardless of sign
	assign den_top = NUM_W'({den, {DIV_STEPS{1'b0}}});
	assign dsh_ext = NUM_W'(dsh_q);
	assign rem_ge  = rem_q >= dsh_ext;
	assign busy    = cnt_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIV_STEPS);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_mag;
			dsh_q <= {den, {(DIV_STEPS-1){1'b0}}};
			quo_q <= '0;
			ovf_q <= num_mag >= den_top;
			neg_q <= num_neg;
		end else if (busy) begin
			if (rem_ge) begin
				rem_q <= rem_q - dsh_ext;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[DIV_STEPS-2:0], rem_ge};
		end
	end

	always_comb begin
		if (neg_q) begin
			if (ovf_q || quo_q > NEG_LIMIT) begin
				quo = SAT_MIN;
			end else begin
				quo = $signed(QUO_W'(0) - quo_q);
			end
		end else if (ovf_q || quo_q[QUO_W-1]) begin
			quo = SAT_MAX;
		end else begin
			quo = $signed(quo_q);
		end
	end

endmodule

// ===== hw/rtl/rsp_cfg.sv =====
// Configuration registers of the projector.
module rsp_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rsp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rsp_pkg::CFG_DATA_W-1:0]  cfg_data,
	output rsp_pkg::cfg_t                   cfg
);
	import rsp_pkg::*;

	cfg_t cfg_q;

	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= SCREEN_WIDTH_RST;
			cfg_q.screen_height <= SCREEN_HEIGHT_RST;
			cfg_q.road_width    <= ROAD_WIDTH_RST;
			cfg_q.camera_height <= CAMERA_HEIGHT_RST;
			cfg_q.camera_depth  <= CAMERA_DEPTH_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SCREEN_WIDTH: begin
					cfg_q.screen_width <= cfg_data[11:0];
				end
				REG_SCREEN_HEIGHT: begin
					cfg_q.screen_height <= cfg_data[11:0];
				end
				REG_ROAD_WIDTH: begin
					cfg_q.road_width <= cfg_data;
				end
				REG_CAMERA_HEIGHT: begin
					cfg_q.camera_height <= cfg_data;
				end
				REG_CAMERA_DEPTH: begin
					cfg_q.camera_depth <= cfg_data;
				end
				default: begin
					// unmapped index: write dropped
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/rsp_dp.sv =====
// Projection datapath: products, numerators, two dividers, running state, result register.
module rsp_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  rsp_pkg::seg_req_t   seg_data,
	input  rsp_pkg::cfg_t       cfg,
	input  rsp_pkg::dp_cmd_t    cmd,
	output rsp_pkg::dp_sts_t    sts,
	output rsp_pkg::proj_req_t  proj_data
);
	import rsp_pkg::*;

	// captured request and running state
	seg_req_t           seg_q;
	logic signed [31:0] curve_off_q;
	logic signed [23:0] curve_slope_q;
	logic signed [15:0] last_cx_q;
	logic signed [15:0] last_ry_q;
	logic signed [15:0] last_hw_q;
	logic               last_valid_q;

	// first product step
	logic signed [20:0] depth_diff;
	logic signed [32:0] camx16;
	logic signed [32:0] camx_adj;
	logic signed [28:0] camx;
	logic        [31:0] num3;
	logic        [19:0] dist_q;
	logic               valid_q;
	logic signed [28:0] camx_q;
	logic        [31:0] wd_q;
	logic        [31:0] hd_q;
	logic        [27:0] wcd_q;
	logic        [27:0] hcd_q;
	logic               shade_q;

	// second product step
	logic signed [57:0] pcx_q;
	logic        [43:0] pry_q;
	logic        [43:0] pw_q;

	// numerators and divisors
	logic signed [58:0] wd_ext;
	logic signed [58:0] pcx_ext;
	logic signed [58:0] ncx_pos;
	logic signed [58:0] ncx_alt;
	logic [NUM_W-1:0]   ncx_mag_q;
	logic               ncx_neg_q;
	logic [NUM_W-1:0]   nry_q;
	logic [NUM_W-1:0]   nhw_q;
	logic [NUM_W-1:0]   nrw_q;
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W-1:0]   denrw_q;

	// dividers
	logic                     div_start;
	logic [NUM_W-1:0]         diva_num;
	logic                     diva_neg;
	logic [NUM_W-1:0]         divb_num;
	logic [DEN_W-1:0]         divb_den;
	logic                     diva_busy;
	logic                     divb_busy;
	logic signed [QUO_W-1:0]  diva_quo;
	logic signed [QUO_W-1:0]  divb_quo;
	logic signed [15:0]       cx_q;
	logic signed [15:0]       hw_q;

	// result
	proj_req_t          proj_d;
	proj_req_t          proj_q;
	logic signed [15:0] half_h;
	logic signed [32:0] off_sum;
	logic signed [24:0] slope_sum;
	logic signed [31:0] off_next;
	logic signed [23:0] slope_next;

	assign depth_diff = $signed({1'b0, seg_q.segment_depth}) - $signed({1'b0, seg_q.camera_z});

	// lateral camera offset in 1/16 units, then truncated toward zero
	assign camx16 = $signed({{5{seg_q.player_offset[23]}}, seg_q.player_offset, 4'b0000})
		- $signed({curve_off_q[31], curve_off_q});
	assign camx_adj = camx16 + $signed({29'd0, {4{camx16[32]}}});
	assign camx     = camx_adj[32:4];
	assign num3     = 32'(seg_q.segment_number) * 32'(DIV3_RECIP);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seg_q <= seg_data;
		end
		if (cmd.mul1) begin
			dist_q  <= depth_diff[19:0];
			valid_q <= !depth_diff[20] && (depth_diff != '0);
			camx_q  <= camx;
			wd_q    <= 32'(cfg.screen_width) * 32'(depth_diff[19:0]);
			hd_q    <= 32'(cfg.screen_height) * 32'(depth_diff[19:0]);
			wcd_q   <= 28'(cfg.screen_width) * 28'(cfg.camera_depth);
			hcd_q   <= 28'(cfg.screen_height) * 28'(cfg.camera_depth);
			shade_q <= num3[DIV3_SHIFT];
		end
		if (cmd.mul2) begin
			pcx_q <= 58'($signed({1'b0, wcd_q})) * 58'(camx_q);
			pry_q <= 44'(hcd_q) * 44'(cfg.camera_height);
			pw_q  <= 44'(wcd_q) * 44'(cfg.road_width);
		end
		if (cmd.num) begin
			ncx_mag_q <= ncx_pos[58] ? ncx_alt[NUM_W-1:0] : ncx_pos[NUM_W-1:0];
			ncx_neg_q <= ncx_pos[58];
			nry_q     <= NUM_W'({hd_q, 16'd0}) + NUM_W'(pry_q);
			nhw_q     <= NUM_W'(pw_q);
			nrw_q     <= NUM_W'({pw_q, 2'b00}) + NUM_W'({pw_q, 1'b0});   // x6
			den_q     <= DEN_W'({dist_q, 17'd0});
			denrw_q   <= DEN_W'({dist_q, 19'd0}) + DEN_W'({dist_q, 17'd0}); // x5
		end
		if (cmd.start_b) begin
			cx_q <= diva_quo;
			hw_q <= divb_quo;
		end
		if (cmd.emit) begin
			proj_q <= proj_d;
		end
	end

	// centre column numerator is signed: both differences side by side, pick by sign
	assign wd_ext  = $signed({11'd0, wd_q, 16'd0});
	assign pcx_ext = $signed({pcx_q[57], pcx_q});
	assign ncx_pos = wd_ext - pcx_ext;
	assign ncx_alt = pcx_ext - wd_ext;

	// lane A: column then row; lane B: half-width then rumble width
	assign div_start = cmd.start_a || cmd.start_b;
	assign diva_num  = cmd.start_a ? ncx_mag_q : nry_q;
	assign diva_neg  = cmd.start_a && ncx_neg_q;
	assign divb_num  = cmd.start_a ? nhw_q : nrw_q;
	assign divb_den  = cmd.start_a ? den_q : denrw_q;

	rsp_div u_div_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_mag (diva_num),
		.num_neg (diva_neg),
		.den     (den_q),
		.busy    (diva_busy),
		.quo     (diva_quo)
	);

	rsp_div u_div_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_mag (divb_num),
		.num_neg (1'b0),
		.den     (divb_den),
		.busy    (divb_busy),
		.quo     (divb_quo)
	);

	assign sts.div_busy = diva_busy || divb_busy;

	assign half_h = $signed({5'd0, cfg.screen_height[11:1]});

	always_comb begin
		proj_d                 = '0;
		proj_d.prev_centre_x   = last_cx_q;
		proj_d.prev_row_y      = last_ry_q;
		proj_d.prev_half_width = last_hw_q;
		proj_d.shade           = shade_q;
		if (valid_q) begin
			proj_d.centre_x     = cx_q;
			proj_d.row_y        = diva_quo;
			proj_d.half_width   = hw_q;
			proj_d.rumble_width = divb_quo;
		end
		proj_d.visible = valid_q && last_valid_q && (last_ry_q >= half_h)
			&& (diva_quo >= half_h);
	end

	assign proj_data = proj_q;

	// curve accumulators, saturating
	assign off_sum   = $signed({curve_off_q[31], curve_off_q})
		+ $signed({{9{curve_slope_q[23]}}, curve_slope_q});
	assign slope_sum = $signed({curve_slope_q[23], curve_slope_q})
		+ $signed({{17{seg_q.segment_curve[7]}}, seg_q.segment_curve});

	always_comb begin
		if (off_sum[32] != off_sum[31]) begin
			off_next = off_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			off_next = off_sum[31:0];
		end
		if (slope_sum[24] != slope_sum[23]) begin
			slope_next = slope_sum[24] ? 24'sh80_0000 : 24'sh7F_FFFF;
		end else begin
			slope_next = slope_sum[23:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_off_q   <= '0;
			curve_slope_q <= '0;
			last_cx_q     <= '0;
			last_ry_q     <= '0;
			last_hw_q     <= '0;
			last_valid_q  <= 1'b0;
		end else if (cmd.load && seg_data.frame_start) begin
			curve_off_q   <= '0;
			curve_slope_q <= '0;
			last_cx_q     <= '0;
			last_ry_q     <= '0;
			last_hw_q     <= '0;
			last_valid_q  <= 1'b0;
		end else if (cmd.emit) begin
			curve_off_q   <= off_next;
			curve_slope_q <= slope_next;
			last_cx_q     <= proj_d.centre_x;
			last_ry_q     <= proj_d.row_y;
			last_hw_q     <= proj_d.half_width;
			last_valid_q  <= valid_q;
		end
	end

endmodule

// ===== hw/rtl/rsp_ctrl.sv =====
// Sequencer of the projector: steps the datapath through one request at a time.
module rsp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               seg_valid,
	output logic               seg_ready,
	output logic               proj_valid,
	input  logic               proj_ready,
	output rsp_pkg::dp_cmd_t   cmd,
	input  rsp_pkg::dp_sts_t   sts
);
	import rsp_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   proj_valid_q;
	logic   slot_free;

	assign slot_free  = !proj_valid_q || proj_ready;
	assign proj_valid = proj_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			proj_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				proj_valid_q <= 1'b1;
			end else if (proj_ready) begin
				proj_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		seg_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				seg_ready = 1'b1;
				if (seg_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_NUM;
			end
			ST_NUM: begin
				cmd.num = 1'b1;
				state_d = ST_START_A;
			end
			ST_START_A: begin
				cmd.start_a = 1'b1;
				state_d     = ST_WAIT_A;
			end
			ST_WAIT_A: begin
				if (!sts.div_busy) begin
					cmd.start_b = 1'b1;
					state_d     = ST_WAIT_B;
				end
			end
			ST_WAIT_B: begin
				if (!sts.div_busy && slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		seg_ready |-> !sts.div_busy)
		else $error("request taken while a division is running");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start_a || cmd.start_b) |=> sts.div_busy)
		else $error("divider did not start");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> proj_valid)
		else $error("result written but not presented");
`endif

endmodule
